[rtl/core/sbce_pkg.sv]
// Shared types and constants for the serial boot command engine.
// No dependencies; imported by the controller, the datapath and the top level.
package sbce_pkg;

   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        jump_valid;
      logic [31:0] jump_entry;
      logic        range_rejected;
      logic        rx_dropped;
      logic        halted;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_en;
      logic load_en;
      logic exec_en;
      logic erase_en;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_done;
      logic erase_req;
      logic erase_done;
   } sts_type;

   localparam logic       OP_RX = 1'b0;

   localparam logic [2:0] PH_HUNT  = 3'd0;
   localparam logic [2:0] PH_CMD   = 3'd1;
   localparam logic [2:0] PH_ADDR  = 3'd2;
   localparam logic [2:0] PH_LEN   = 3'd3;
   localparam logic [2:0] PH_WDATA = 3'd4;
   localparam logic [2:0] PH_RDATA = 3'd5;
   localparam logic [2:0] PH_JADDR = 3'd6;

   localparam logic [7:0] CODE_STORE = 8'h57;
   localparam logic [7:0] CODE_FETCH = 8'h47;
   localparam logic [7:0] CODE_GO    = 8'h4A;
   localparam logic [7:0] CODE_WIPE  = 8'h45;
   localparam logic [7:0] FILL_BYTE  = 8'hFF;

   localparam logic [1:0] REG_BASE     = 2'd0;
   localparam logic [1:0] REG_SIZE     = 2'd1;
   localparam logic [1:0] REG_ER_OFF   = 2'd2;
   localparam logic [1:0] REG_ER_LEN   = 2'd3;
   localparam int         CSR_IDX_W    = 8;

   localparam logic [3:0] BANNER_LEN = 4'd14;

   function automatic logic [7:0] banner_byte(input logic [3:0] idx);
      case (idx)
         4'd0:    banner_byte = 8'h4D;
         4'd1:    banner_byte = 8'h49;
         4'd2:    banner_byte = 8'h4C;
         4'd3:    banner_byte = 8'h49;
         4'd4:    banner_byte = 8'h2D;
         4'd5:    banner_byte = 8'h42;
         4'd6:    banner_byte = 8'h4F;
         4'd7:    banner_byte = 8'h4F;
         4'd8:    banner_byte = 8'h54;
         4'd9:    banner_byte = 8'h2D;
         4'd10:   banner_byte = 8'h76;
         4'd11:   banner_byte = 8'h31;
         4'd12:   banner_byte = 8'h0D;
         4'd13:   banner_byte = 8'h0A;
         default: banner_byte = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      case (idx)
         2'd0:    magic_byte = 8'h42;
         2'd1:    magic_byte = 8'h4E;
         2'd2:    magic_byte = 8'h31;
         default: magic_byte = 8'h00;
      endcase
   endfunction

endpackage

[rtl/core/serial_boot_command_engine.sv]
// Top level of the serial boot command engine.
// Depends on sbce_pkg, sbce_ctrl and sbce_datapath.
//
//   channel  ports                          direction
//   req      req_valid req_stall req_data   in  (rx byte or tx slot)
//   rsp      rsp_valid rsp_stall rsp_data   out (one result per item)
//   csr      csr_we csr_index csr_wdata     in  (write only)
//
// An item passes through intake, execute and result; the result register holds
// until taken. An erase adds a memory write-port sweep between execute and result
// that writes min(erase_length, MEM_DEPTH - erase_offset) bytes, the second term
// taken as zero when the offset is at or past the end. After reset a clearing pass
// zeroes the memory while intake is stalled; csr writes are taken always.
module serial_boot_command_engine #(
   parameter int MEM_DEPTH = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  sbce_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output sbce_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [sbce_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata
);
   import sbce_pkg::*;

   cmd_type cmd;
   sts_type sts;

   sbce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   sbce_datapath #(.MEM_DEPTH(MEM_DEPTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );
endmodule

[rtl/core/sbce_ctrl.sv]
// Sequencer for the boot engine: clear pass, intake, execute, erase sweep, result hold.
// Depends on sbce_pkg for the command and status structs.
module sbce_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sbce_pkg::cmd_type cmd,
   input  sbce_pkg::sts_type sts
);
   import sbce_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_ERASE = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (sts.clear_done) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid) state_in = ST_EXEC;
         ST_EXEC:  state_in = sts.erase_req ? ST_ERASE : ST_OUT;
         ST_ERASE: if (sts.erase_done) state_in = ST_OUT;
         ST_OUT:   if (!rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = (state_ff == ST_OUT);
   assign cmd.clear_en = (state_ff == ST_CLEAR);
   assign cmd.load_en  = (state_ff == ST_IDLE) && req_valid;
   assign cmd.exec_en  = (state_ff == ST_EXEC);
   assign cmd.erase_en = (state_ff == ST_ERASE);

   a_exec_next: assert property (@(posedge clock) disable iff (reset)
      cmd.exec_en |=> (state_ff == ST_ERASE || state_ff == ST_OUT))
      else $error("execute step not followed by erase or result");
   a_erase_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.erase_en && sts.erase_done) |=> rsp_valid)
      else $error("erase end did not present a result");
   a_load_once: assert property (@(posedge clock) disable iff (reset)
      cmd.load_en |=> (req_stall && !cmd.load_en))
      else $error("intake open while an item is in flight");
endmodule

[rtl/core/sbce_datapath.sv]
// Datapath of the boot engine: registers, parse state, boot memory and result register.
// Depends on sbce_pkg; sequenced by sbce_ctrl.
module sbce_datapath #(
   parameter int MEM_DEPTH = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [sbce_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                csr_wdata,
   input  sbce_pkg::req_type          req_data,
   output sbce_pkg::rsp_type          rsp_data,
   input  sbce_pkg::cmd_type          cmd,
   output sbce_pkg::sts_type          sts
);
   import sbce_pkg::*;

   localparam int AW  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int EPW = (AW + 1 > 14) ? AW + 1 : 14;

   // configuration
   logic [31:0] base_ff;
   logic [12:0] size_ff, er_len_ff;
   logic [11:0] er_off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         size_ff   <= 13'd4096;
         er_off_ff <= '0;
         er_len_ff <= 13'd4096;
      end else if (csr_we && csr_index[CSR_IDX_W-1:2] == '0) begin
         case (csr_index[1:0])
            REG_BASE:   base_ff   <= csr_wdata;
            REG_SIZE:   size_ff   <= csr_wdata[12:0];
            REG_ER_OFF: er_off_ff <= csr_wdata[11:0];
            REG_ER_LEN: er_len_ff <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // engine state
   logic [2:0]    phase_ff, phase_in;
   logic [1:0]    gcnt_ff, gcnt_in;
   logic          gmatch_ff, gmatch_in;
   logic [7:0]    code_ff, code_in;
   logic [1:0]    fbc_ff, fbc_in;
   logic [31:0]   addr_ff, addr_in;
   logic [31:0]   len_ff, len_in;
   logic [AW-1:0] cursor_ff, cursor_in;
   logic [AW:0]   rem_ff, rem_in;
   logic [3:0]    ban_ff, ban_in;
   logic          stop_ff, stop_in;
   logic          erq_in;
   req_type       in_ff;
   rsp_type       rsp_ff, rsp_in;

   logic [7:0]    mem [MEM_DEPTH];
   logic [7:0]    rd_ff;
   logic [AW-1:0] clr_ff;
   logic [EPW-1:0] epos_ff;
   logic [12:0]   ecnt_ff;

   logic [7:0]  b;
   logic [31:0] addr_new, len_new, offs;
   logic [32:0] sum, usable, size33, depth33;
   logic        erase_active;

   assign b        = in_ff.rx_byte;
   assign size33   = 33'(size_ff);
   assign depth33  = 33'(MEM_DEPTH);
   assign usable   = (size33 < depth33) ? size33 : depth33;

   always_comb begin
      addr_new = addr_ff;
      len_new  = len_ff;
      case (fbc_ff)
         2'd0:    begin addr_new[7:0]   = b; len_new[7:0]   = b; end
         2'd1:    begin addr_new[15:8]  = b; len_new[15:8]  = b; end
         2'd2:    begin addr_new[23:16] = b; len_new[23:16] = b; end
         default: begin addr_new[31:24] = b; len_new[31:24] = b; end
      endcase
   end

   // offset taken against the base register at the last length byte
   assign offs = addr_ff - base_ff;
   assign sum  = {1'b0, offs} + {1'b0, len_new};

   always_comb begin
      phase_in  = phase_ff;
      gcnt_in   = gcnt_ff;
      gmatch_in = gmatch_ff;
      code_in   = code_ff;
      fbc_in    = fbc_ff;
      addr_in   = addr_ff;
      len_in    = len_ff;
      cursor_in = cursor_ff;
      rem_in    = rem_ff;
      ban_in    = ban_ff;
      stop_in   = stop_ff;
      erq_in    = 1'b0;
      rsp_in    = '0;

      if (in_ff.op != OP_RX) begin
         if (!stop_ff) begin
            if (ban_ff < BANNER_LEN) begin
               rsp_in.tx_valid = 1'b1;
               rsp_in.tx_byte  = banner_byte(ban_ff);
               ban_in          = ban_ff + 4'd1;
            end else if (phase_ff == PH_RDATA) begin
               rsp_in.tx_valid = 1'b1;
               rsp_in.tx_byte  = rd_ff;
               cursor_in       = cursor_ff + 1'b1;
               rem_in          = rem_ff - 1'b1;
               if (rem_ff == (AW+1)'(1)) begin
                  phase_in = PH_HUNT; gcnt_in = '0; gmatch_in = 1'b1;
               end
            end
         end
      end else if (stop_ff || ban_ff < BANNER_LEN || phase_ff == PH_RDATA) begin
         rsp_in.rx_dropped = 1'b1;
      end else begin
         case (phase_ff)
            PH_HUNT: begin
               if (b != magic_byte(gcnt_ff)) gmatch_in = 1'b0;
               gcnt_in = gcnt_ff + 2'd1;
               if (gcnt_ff == 2'd2) begin
                  // fixed groups of three, no sliding
                  gcnt_in   = '0;
                  gmatch_in = 1'b1;
                  if (gmatch_ff && b == magic_byte(gcnt_ff)) phase_in = PH_CMD;
               end
            end
            PH_CMD: begin
               code_in = b;
               fbc_in  = '0;
               addr_in = '0;
               len_in  = '0;
               if (b == CODE_STORE || b == CODE_FETCH) begin
                  phase_in = PH_ADDR;
               end else if (b == CODE_GO) begin
                  phase_in = PH_JADDR;
               end else begin
                  erq_in   = (b == CODE_WIPE);
                  phase_in = PH_HUNT; gcnt_in = '0; gmatch_in = 1'b1;
               end
            end
            PH_ADDR, PH_JADDR: begin
               addr_in = addr_new;
               fbc_in  = fbc_ff + 2'd1;
               if (fbc_ff == 2'd3) begin
                  if (phase_ff == PH_JADDR) begin
                     rsp_in.jump_valid = 1'b1;
                     rsp_in.jump_entry = addr_new;
                     stop_in  = 1'b1;
                     phase_in = PH_HUNT; gcnt_in = '0; gmatch_in = 1'b1;
                  end else begin
                     phase_in = PH_LEN;
                  end
               end
            end
            PH_LEN: begin
               len_in = len_new;
               fbc_in = fbc_ff + 2'd1;
               if (fbc_ff == 2'd3) begin
                  if (sum > usable) begin
                     rsp_in.range_rejected = 1'b1;
                     phase_in = PH_HUNT; gcnt_in = '0; gmatch_in = 1'b1;
                  end else begin
                     // passing the test bounds both values to at most the memory depth
                     cursor_in = offs[AW-1:0];
                     rem_in    = len_new[AW:0];
                     if (len_new == '0) begin
                        phase_in = PH_HUNT; gcnt_in = '0; gmatch_in = 1'b1;
                     end else begin
                        phase_in = (code_ff == CODE_STORE) ? PH_WDATA : PH_RDATA;
                     end
                  end
               end
            end
            PH_WDATA: begin
               cursor_in = cursor_ff + 1'b1;
               rem_in    = rem_ff - 1'b1;
               if (rem_ff == (AW+1)'(1)) begin
                  phase_in = PH_HUNT; gcnt_in = '0; gmatch_in = 1'b1;
               end
            end
            default: begin
               phase_in = PH_HUNT; gcnt_in = '0; gmatch_in = 1'b1;
            end
         endcase
      end
      rsp_in.halted = stop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         gcnt_ff   <= '0;
         gmatch_ff <= 1'b1;
         code_ff   <= '0;
         fbc_ff    <= '0;
         addr_ff   <= '0;
         len_ff    <= '0;
         cursor_ff <= '0;
         rem_ff    <= '0;
         ban_ff    <= '0;
         stop_ff   <= 1'b0;
      end else if (cmd.exec_en) begin
         phase_ff  <= phase_in;
         gcnt_ff   <= gcnt_in;
         gmatch_ff <= gmatch_in;
         code_ff   <= code_in;
         fbc_ff    <= fbc_in;
         addr_ff   <= addr_in;
         len_ff    <= len_in;
         cursor_ff <= cursor_in;
         rem_ff    <= rem_in;
         ban_ff    <= ban_in;
         stop_ff   <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_en) in_ff <= req_data;
      if (cmd.exec_en) rsp_ff <= rsp_in;
   end

   // clear pass and erase sweep counters
   assign erase_active = (ecnt_ff != '0) && (epos_ff < EPW'(MEM_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear_en) clr_ff <= clr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.exec_en) begin
         epos_ff <= EPW'(er_off_ff);
         ecnt_ff <= er_len_ff;
      end else if (cmd.erase_en && erase_active) begin
         epos_ff <= epos_ff + 1'b1;
         ecnt_ff <= ecnt_ff - 13'd1;
      end
   end

   // single write port, registered read at the cursor
   always_ff @(posedge clock) begin
      if (cmd.clear_en)
         mem[clr_ff] <= 8'h00;
      else if (cmd.erase_en && erase_active)
         mem[epos_ff[AW-1:0]] <= FILL_BYTE;
      else if (cmd.exec_en && in_ff.op == OP_RX && !stop_ff && ban_ff >= BANNER_LEN
               && phase_ff == PH_WDATA)
         mem[cursor_ff] <= b;
      rd_ff <= mem[cursor_ff];
   end

   assign sts.clear_done = cmd.clear_en && (clr_ff == AW'(MEM_DEPTH - 1));
   assign sts.erase_req  = erq_in;
   assign sts.erase_done = !erase_active;
   assign rsp_data       = rsp_ff;

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      stop_ff |=> stop_ff)
      else $error("halt cleared without reset");
   a_data_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_WDATA || phase_ff == PH_RDATA) |-> (rem_ff != '0))
      else $error("data phase with nothing remaining");
   a_erase_fill: assert property (@(posedge clock) disable iff (reset)
      (cmd.erase_en && erase_active) |=> (ecnt_ff == $past(ecnt_ff) - 13'd1))
      else $error("erase count did not advance");
endmodule

[bench/tb_top.sv]
// Self-checking bench for serial_boot_command_engine: a queue-fed driver, a
// result monitor and a byte-level predictor of the boot parser and its memory.
// Depends on sbce_pkg and the RTL top level only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sbce_pkg::*;

   localparam int          DEPTH     = 4096;
   localparam int          LIMIT     = 3_000_000;
   localparam logic [7:0]  MAGIC_B   = 8'h42;
   localparam logic [7:0]  MAGIC_N   = 8'h4E;
   localparam logic [7:0]  MAGIC_1   = 8'h31;
   localparam logic [7:0]  REG_BOGUS = 8'd4;
   localparam logic [7:0]  BANNER_TEXT [14] = '{8'h4D, 8'h49, 8'h4C, 8'h49, 8'h2D, 8'h42,
      8'h4F, 8'h4F, 8'h54, 8'h2D, 8'h76, 8'h31, 8'h0D, 8'h0A};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   always #1 clock = ~clock;

   serial_boot_command_engine u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor copy of configuration and engine state
   logic [31:0] cfg_base;
   logic [12:0] cfg_size;
   logic [11:0] cfg_er_off;
   logic [12:0] cfg_er_len;
   logic [7:0]  mem_image [DEPTH];
   logic [2:0]  parse_ph;
   int unsigned grp_cnt;
   logic        grp_ok;
   logic [7:0]  cmd_code;
   int unsigned fld_cnt;
   logic [31:0] addr_acc, len_acc;
   int unsigned rd_ptr, left_cnt, banner_pos;
   logic        is_halted;

   req_type pending_q [$];
   rsp_type expected_q [$];
   int fail_count = 0;
   int n_items = 0, n_tx = 0, n_rejects = 0, n_drops = 0, n_erases = 0, n_results = 0;
   logic idle_en = 1'b0;
   int send_gap = 0, stall_gap = 0;
   int cycle_cnt = 0;

   function automatic int pick_gap();
      if (!idle_en || $urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function void boot_state_reset();
      cfg_base = 32'd0;
      cfg_size = 13'd4096;
      cfg_er_off = 12'd0;
      cfg_er_len = 13'd4096;
      foreach (mem_image[i]) mem_image[i] = 8'h00;
      parse_ph = PH_HUNT;
      grp_cnt = 0;
      grp_ok = 1'b1;
      cmd_code = 8'h00;
      fld_cnt = 0;
      addr_acc = 32'd0;
      len_acc = 32'd0;
      rd_ptr = 0;
      left_cnt = 0;
      banner_pos = 0;
      is_halted = 1'b0;
   endfunction

   function void rehunt();
      parse_ph = PH_HUNT;
      grp_cnt = 0;
      grp_ok = 1'b1;
   endfunction

   function automatic rsp_type boot_engine_result(input req_type r);
      rsp_type     res;
      logic [7:0]  magic [3];
      int unsigned usable, pos, cnt;
      logic [31:0] offset;
      res = '0;
      magic = '{MAGIC_B, MAGIC_N, MAGIC_1};
      if (r.op != OP_RX) begin
         if (!is_halted) begin
            if (banner_pos < 14) begin
               res.tx_valid = 1'b1;
               res.tx_byte = BANNER_TEXT[banner_pos];
               banner_pos++;
            end else if (parse_ph == PH_RDATA) begin
               res.tx_valid = 1'b1;
               res.tx_byte = (rd_ptr < DEPTH) ? mem_image[rd_ptr] : 8'h00;
               rd_ptr++;
               left_cnt--;
               if (left_cnt == 0) rehunt();
            end
         end
      end else if (is_halted || banner_pos < 14 || parse_ph == PH_RDATA) begin
         res.rx_dropped = 1'b1;
      end else begin
         case (parse_ph)
            PH_HUNT: begin
               if (r.rx_byte != magic[grp_cnt]) grp_ok = 1'b0;
               grp_cnt++;
               if (grp_cnt >= 3) begin
                  if (grp_ok) begin
                     rehunt();
                     parse_ph = PH_CMD;
                  end else rehunt();
               end
            end
            PH_CMD: begin
               cmd_code = r.rx_byte;
               fld_cnt = 0;
               addr_acc = 32'd0;
               len_acc = 32'd0;
               if (r.rx_byte == CODE_STORE || r.rx_byte == CODE_FETCH) parse_ph = PH_ADDR;
               else if (r.rx_byte == CODE_GO) parse_ph = PH_JADDR;
               else begin
                  if (r.rx_byte == CODE_WIPE) begin
                     n_erases++;
                     pos = 32'(cfg_er_off);
                     cnt = 32'(cfg_er_len);
                     while (cnt > 0 && pos < DEPTH) begin
                        mem_image[pos] = FILL_BYTE;
                        pos++;
                        cnt--;
                     end
                  end
                  rehunt();
               end
            end
            PH_ADDR, PH_JADDR: begin
               addr_acc |= 32'(r.rx_byte) << (8 * fld_cnt);
               fld_cnt = (fld_cnt + 1) % 4;
               if (fld_cnt == 0) begin
                  if (parse_ph == PH_JADDR) begin
                     res.jump_valid = 1'b1;
                     res.jump_entry = addr_acc;
                     is_halted = 1'b1;
                     rehunt();
                  end else parse_ph = PH_LEN;
               end
            end
            PH_LEN: begin
               len_acc |= 32'(r.rx_byte) << (8 * fld_cnt);
               fld_cnt = (fld_cnt + 1) % 4;
               if (fld_cnt == 0) begin
                  usable = (32'(cfg_size) > DEPTH) ? DEPTH : 32'(cfg_size);
                  offset = addr_acc - cfg_base;
                  // no wraparound in the bounds sum
                  if (({1'b0, offset} + {1'b0, len_acc}) > 33'(usable)) begin
                     res.range_rejected = 1'b1;
                     n_rejects++;
                     rehunt();
                  end else begin
                     rd_ptr = offset;
                     left_cnt = len_acc;
                     if (left_cnt == 0) rehunt();
                     else parse_ph = (cmd_code == CODE_STORE) ? PH_WDATA : PH_RDATA;
                  end
               end
            end
            PH_WDATA: begin
               if (rd_ptr < DEPTH) mem_image[rd_ptr] = r.rx_byte;
               rd_ptr++;
               left_cnt--;
               if (left_cnt == 0) rehunt();
            end
            default: rehunt();
         endcase
      end
      res.halted = is_halted;
      if (res.tx_valid) n_tx++;
      if (res.rx_dropped) n_drops++;
      return res;
   endfunction

   // driver: prediction is made as each item is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            expected_q.push_back(boot_engine_result(req_data));
            n_items++;
         end
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            req_data <= pending_q.pop_front();
            req_valid <= 1'b1;
            send_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and result stall
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (expected_q.size() == 0) begin
               $error("result with no expectation waiting: %p", rsp_data);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.tx_valid !== want.tx_valid) begin
                  $error("tx_valid exp %0h got %0h", want.tx_valid, rsp_data.tx_valid);
                  fail_count++;
               end
               if (rsp_data.tx_byte !== want.tx_byte) begin
                  $error("tx_byte exp %0h got %0h", want.tx_byte, rsp_data.tx_byte);
                  fail_count++;
               end
               if (rsp_data.jump_valid !== want.jump_valid) begin
                  $error("jump_valid exp %0h got %0h", want.jump_valid, rsp_data.jump_valid);
                  fail_count++;
               end
               if (rsp_data.jump_entry !== want.jump_entry) begin
                  $error("jump_entry exp %0h got %0h", want.jump_entry, rsp_data.jump_entry);
                  fail_count++;
               end
               if (rsp_data.range_rejected !== want.range_rejected) begin
                  $error("range_rejected exp %0h got %0h", want.range_rejected,
                         rsp_data.range_rejected);
                  fail_count++;
               end
               if (rsp_data.rx_dropped !== want.rx_dropped) begin
                  $error("rx_dropped exp %0h got %0h", want.rx_dropped, rsp_data.rx_dropped);
                  fail_count++;
               end
               if (rsp_data.halted !== want.halted) begin
                  $error("halted exp %0h got %0h", want.halted, rsp_data.halted);
                  fail_count++;
               end
            end
         end
         if (stall_gap > 0) begin
            stall_gap <= stall_gap - 1;
            rsp_stall <= 1'b1;
         end else begin
            stall_gap <= pick_gap();
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == LIMIT) begin
         $display("** serial_boot_command_engine: FAILED **");
         $finish;
      end
   end

   task automatic csr_write(input logic [7:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         8'(REG_BASE):   cfg_base = val;
         8'(REG_SIZE):   cfg_size = val[12:0];
         8'(REG_ER_OFF): cfg_er_off = val[11:0];
         8'(REG_ER_LEN): cfg_er_len = val[12:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [31:0] base, input logic [31:0] size,
                            input logic [31:0] er_off, input logic [31:0] er_len);
      csr_write(8'(REG_BASE), base);
      csr_write(8'(REG_SIZE), size);
      csr_write(8'(REG_ER_OFF), er_off);
      csr_write(8'(REG_ER_LEN), er_len);
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_q.size() != 0 || req_valid || expected_q.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   function void push_rx(input logic [7:0] b);
      req_type it;
      it.op = OP_RX;
      it.rx_byte = b;
      pending_q.push_back(it);
   endfunction

   function void push_slot();
      req_type it;
      it.op = ~OP_RX;
      it.rx_byte = 8'($urandom_range(0, 255));  // ignored on a tx slot
      pending_q.push_back(it);
   endfunction

   function void push_word(input logic [31:0] w);
      for (int i = 0; i < 4; i++) push_rx(w[8*i +: 8]);
   endfunction

   function void push_magic();
      push_rx(MAGIC_B);
      push_rx(MAGIC_N);
      push_rx(MAGIC_1);
   endfunction

   function void push_transfer(input logic [7:0] cmd, input logic [31:0] addr,
                               input logic [31:0] len);
      push_magic();
      push_rx(cmd);
      push_word(addr);
      push_word(len);
      if (len <= 64) begin
         for (int i = 0; i < len; i++) begin
            if (cmd == CODE_STORE) push_rx(8'($urandom_range(0, 255)));
            else push_slot();
            // stray traffic inside the data phase
            if ($urandom_range(0, 15) == 0) begin
               if (cmd == CODE_STORE) push_slot();
               else push_rx(8'($urandom_range(0, 255)));
            end
         end
      end
   endfunction

   task automatic random_traffic(input int count);
      int unsigned usable, off, len, sel;
      logic [31:0] addr;
      int start;
      start = pending_q.size();
      usable = (32'(cfg_size) > DEPTH) ? DEPTH : 32'(cfg_size);
      while (pending_q.size() - start < count) begin
         sel = $urandom_range(0, 99);
         if (sel < 55) begin
            off = $urandom_range(0, usable);
            len = $urandom_range(0, 16);
            if (off > usable - 8 && usable >= 8) len = $urandom_range(0, 10);
            addr = cfg_base + off;
            case ($urandom_range(0, 9))
               0: addr = $urandom;
               1: len = $urandom;
               2: len = 32'hFFFF_FFFF;
               default: ;
            endcase
            push_transfer(($urandom_range(0, 1) != 0) ? CODE_STORE : CODE_FETCH, addr, len);
         end else if (sel < 60) begin
            push_magic();
            push_rx(CODE_WIPE);
         end else if (sel < 67) begin
            push_magic();
            push_rx(8'($urandom_range(0, 255)));
         end else if (sel < 75) begin
            push_rx(MAGIC_B);
            push_rx($urandom_range(0, 1) ? MAGIC_1 : MAGIC_N);
            push_rx(8'($urandom_range(0, 255)));
         end else if (sel < 88) begin
            push_rx(8'($urandom_range(0, 255)));
         end else begin
            push_slot();
         end
      end
   endtask

   initial begin
      boot_state_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // default settings, then the banner with bytes arriving during it
      configure(32'd0, 32'd4096, 32'd0, 32'd4096);
      csr_write(REG_BOGUS, 32'h1234_5678);
      push_rx(MAGIC_B);
      for (int i = 0; i < 15; i++) push_slot();
      push_transfer(CODE_STORE, 32'd0, 32'd2);
      push_transfer(CODE_FETCH, 32'd0, 32'd2);
      push_magic();
      push_rx(CODE_WIPE);
      push_transfer(CODE_FETCH, 32'd4094, 32'd2);
      push_transfer(CODE_STORE, 32'd4095, 32'd2);  // one past the end
      push_transfer(CODE_FETCH, 32'd0, 32'd0);
      push_magic();
      push_rx(8'h00);
      drain();

      idle_en = 1'b1;
      configure(32'd0, 32'd4096, 32'd4000, 32'd8);
      random_traffic(420);
      drain();

      // base near the top of the address space; erase clipped to the last byte
      idle_en = 1'b0;
      configure(32'hFFFF_FFF0, 32'd100, 32'd4095, 32'd4096);
      random_traffic(420);
      drain();

      idle_en = 1'b1;
      configure(32'h0800_0000, 32'd0, 32'd0, 32'd0);
      random_traffic(200);
      drain();

      // size register above the memory depth
      configure(32'h0000_1000, 32'h1FFF, 32'h100, 32'd64);
      random_traffic(420);
      push_magic();
      push_rx(CODE_GO);
      push_word($urandom);
      for (int i = 0; i < 20; i++) begin
         if ($urandom_range(0, 1) != 0) push_slot();
         else push_rx(8'($urandom_range(0, 255)));
      end
      drain();

      $display("items %0d, results %0d: %0d bytes sent, %0d erases, %0d range rejects",
               n_items, n_results, n_tx, n_erases, n_rejects);
      $display("%0d received bytes dropped; engine halted by a jump at the end", n_drops);
      if (fail_count == 0) begin
         $display("** serial_boot_command_engine: PASSED **");
      end else begin
         $display("** serial_boot_command_engine: FAILED **");
      end
      $finish;
   end

endmodule
